// ----- sv/isc_pkg.sv -----
// Shared types, request codes, register indexes and reset values for the submit schedule checker.
package isc_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 24;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SUBMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SLOT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD_FRAMES = 2'd3;

  localparam logic [7:0] RST_FRAMES_PER_SLOT = 8'd1;
  localparam logic [7:0] RST_SLOTS_PER_SUBMIT = 8'd8;
  localparam logic [15:0] RST_BYTES_PER_SLOT = 16'd192;
  localparam logic [47:0] RST_MIN_LEAD_FRAMES = 48'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic direction;
    logic [7:0] slots;
    logic [23:0] bytes;
    logic [23:0] frames;
    logic [47:0] first_stamp;
    logic [31:0] first_seq;
    logic [47:0] submit_time;
  } req_t;

  typedef struct packed {
    logic ok;
    logic shape_safe;
    logic lead_safe;
    logic order_safe;
    logic all_safe;
    logic [31:0] scheduled_count;
    logic [31:0] capture_count;
    logic [31:0] late_count;
    logic [47:0] min_lead;
    logic [47:0] max_lead;
    logic [47:0] frames_total;
    logic [47:0] bytes_total;
  } rsp_t;

endpackage

// ----- sv/iso_submit_schedule_checker_unit.sv -----
// Top level of the isochronous submit schedule checker.
// Each request (submit descriptor, start or stop) gives exactly one result in the cycle after
// its transfer, and a new request can be taken in every cycle while out_ready stays high. The
// result sits in an output register; a request is taken whenever that register is empty or
// being drained in the same cycle, so the sustained rate is one request per cycle, set by the
// update of the checker state. A start latches the expected descriptor size from the live
// registers, so a submit may follow a start in the very next cycle.
module iso_submit_schedule_checker_unit #(
  parameter int unsigned FRAME_BYTES = isc_pkg::FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  isc_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output isc_pkg::rsp_t out_data,
  input  logic cfg_we,
  input  logic [isc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FbW = $clog2(FRAME_BYTES + 1);
  localparam int PrW = 24 + FbW + 1;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v, input logic en);
    logic [31:0] r;
    r = v;
    if (en && (v != '1)) begin
      r = v + 32'd1;
    end
    return r;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [23:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  logic [7:0] reg_fps;
  logic [7:0] reg_sps;
  logic [15:0] reg_bps;
  logic [47:0] reg_minlead;

  logic [7:0] act_sps;
  logic [23:0] act_exp_bytes;
  logic [47:0] act_minlead;

  logic running;
  logic [1:0] seen;
  logic [47:0] last_stamp [2];
  logic [31:0] last_seq [2];
  logic shape_bad;
  logic mono_bad;
  logic [31:0] late_cnt;
  logic [31:0] sched_cnt;
  logic [31:0] capture_cnt;
  logic [47:0] frame_sum;
  logic [47:0] byte_sum;
  logic [47:0] lead_min;
  logic [47:0] lead_max;

  logic [7:0] act_sps_next;
  logic [23:0] act_exp_bytes_next;
  logic [47:0] act_minlead_next;
  logic running_next;
  logic [1:0] seen_next;
  logic shape_bad_next;
  logic mono_bad_next;
  logic [31:0] late_cnt_next;
  logic [31:0] sched_cnt_next;
  logic [31:0] capture_cnt_next;
  logic [47:0] frame_sum_next;
  logic [47:0] byte_sum_next;
  logic [47:0] lead_min_next;
  logic [47:0] lead_max_next;
  logic wr_hist;
  logic ok_next;
  isc_pkg::rsp_t out_data_next;

  logic accept;
  logic start_ok;
  logic [PrW-1:0] frame_lo;
  logic [PrW-1:0] frame_hi;
  logic [PrW-1:0] exp_ext;
  logic frame_match;
  logic shape_err;
  logic stamp_reg;
  logic seq_reg;
  logic [47:0] lead;
  logic late;
  logic deadline_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  assign start_ok = (reg_fps != '0) && (reg_sps != '0) && (reg_bps != '0) &&
                    (reg_minlead != '0);

  assign exp_ext = PrW'(act_exp_bytes);
  assign frame_lo = PrW'(in_data.frames) * PrW'(FRAME_BYTES);
  assign frame_hi = frame_lo + PrW'(FRAME_BYTES);
  assign frame_match = (frame_lo <= exp_ext) && (exp_ext < frame_hi);

  assign shape_err = (in_data.slots != act_sps) || (in_data.bytes != act_exp_bytes) ||
                     !frame_match || (in_data.first_stamp == '0);
  assign stamp_reg = seen[in_data.direction] &&
                     (in_data.first_stamp <= last_stamp[in_data.direction]);
  assign seq_reg = seen[in_data.direction] && (in_data.first_seq <= last_seq[in_data.direction]);
  assign lead = (in_data.first_stamp > in_data.submit_time) ?
                (in_data.first_stamp - in_data.submit_time) : '0;
  assign late = lead < act_minlead;

  always_comb begin
    act_sps_next = act_sps;
    act_exp_bytes_next = act_exp_bytes;
    act_minlead_next = act_minlead;
    running_next = running;
    seen_next = seen;
    shape_bad_next = shape_bad;
    mono_bad_next = mono_bad;
    late_cnt_next = late_cnt;
    sched_cnt_next = sched_cnt;
    capture_cnt_next = capture_cnt;
    frame_sum_next = frame_sum;
    byte_sum_next = byte_sum;
    lead_min_next = lead_min;
    lead_max_next = lead_max;
    wr_hist = 1'b0;
    ok_next = 1'b0;
    unique case (in_data.req_type)
      isc_pkg::REQ_SUBMIT: begin
        if (running) begin
          wr_hist = 1'b1;
          ok_next = !shape_err && !stamp_reg && !seq_reg && !late;
          shape_bad_next = shape_bad || shape_err;
          mono_bad_next = mono_bad || stamp_reg || seq_reg;
          late_cnt_next = sat_inc32(late_cnt, late);
          sched_cnt_next = sat_inc32(sched_cnt, 1'b1);
          capture_cnt_next = sat_inc32(capture_cnt, !in_data.direction);
          frame_sum_next = sat_add48(frame_sum, in_data.frames);
          byte_sum_next = sat_add48(byte_sum, in_data.bytes);
          seen_next[in_data.direction] = 1'b1;
          if (lead < lead_min) begin
            lead_min_next = lead;
          end
          if (lead > lead_max) begin
            lead_max_next = lead;
          end
        end
      end
      isc_pkg::REQ_START: begin
        if (start_ok) begin
          ok_next = 1'b1;
          act_sps_next = reg_sps;
          act_exp_bytes_next = 24'(reg_sps * reg_bps);
          act_minlead_next = reg_minlead;
          running_next = 1'b1;
          seen_next = '0;
          shape_bad_next = 1'b0;
          mono_bad_next = 1'b0;
          late_cnt_next = '0;
          sched_cnt_next = '0;
          capture_cnt_next = '0;
          frame_sum_next = '0;
          byte_sum_next = '0;
          lead_min_next = '1;
          lead_max_next = '0;
        end
      end
      isc_pkg::REQ_STOP: begin
        ok_next = 1'b1;
        running_next = 1'b0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase

    deadline_ok = (sched_cnt_next != '0) && (late_cnt_next == '0) &&
                  (lead_min_next >= act_minlead_next);
    out_data_next.ok = ok_next;
    out_data_next.shape_safe = !shape_bad_next;
    out_data_next.lead_safe = deadline_ok;
    out_data_next.order_safe = !mono_bad_next;
    out_data_next.all_safe = !shape_bad_next && deadline_ok && !mono_bad_next;
    out_data_next.scheduled_count = sched_cnt_next;
    out_data_next.capture_count = capture_cnt_next;
    out_data_next.late_count = late_cnt_next;
    out_data_next.min_lead = lead_min_next;
    out_data_next.max_lead = lead_max_next;
    out_data_next.frames_total = frame_sum_next;
    out_data_next.bytes_total = byte_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_fps <= isc_pkg::RST_FRAMES_PER_SLOT;
      reg_sps <= isc_pkg::RST_SLOTS_PER_SUBMIT;
      reg_bps <= isc_pkg::RST_BYTES_PER_SLOT;
      reg_minlead <= isc_pkg::RST_MIN_LEAD_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isc_pkg::CFG_FRAMES_PER_SLOT: reg_fps <= cfg_data[7:0];
        isc_pkg::CFG_SLOTS_PER_SUBMIT: reg_sps <= cfg_data[7:0];
        isc_pkg::CFG_BYTES_PER_SLOT: reg_bps <= cfg_data[15:0];
        isc_pkg::CFG_MIN_LEAD_FRAMES: reg_minlead <= cfg_data[47:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_sps <= isc_pkg::RST_SLOTS_PER_SUBMIT;
      act_exp_bytes <= 24'(isc_pkg::RST_SLOTS_PER_SUBMIT * isc_pkg::RST_BYTES_PER_SLOT);
      act_minlead <= isc_pkg::RST_MIN_LEAD_FRAMES;
      running <= 1'b0;
      seen <= '0;
      shape_bad <= 1'b0;
      mono_bad <= 1'b0;
      late_cnt <= '0;
      sched_cnt <= '0;
      capture_cnt <= '0;
      frame_sum <= '0;
      byte_sum <= '0;
      lead_min <= '1;
      lead_max <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        act_sps <= act_sps_next;
        act_exp_bytes <= act_exp_bytes_next;
        act_minlead <= act_minlead_next;
        running <= running_next;
        seen <= seen_next;
        shape_bad <= shape_bad_next;
        mono_bad <= mono_bad_next;
        late_cnt <= late_cnt_next;
        sched_cnt <= sched_cnt_next;
        capture_cnt <= capture_cnt_next;
        frame_sum <= frame_sum_next;
        byte_sum <= byte_sum_next;
        lead_min <= lead_min_next;
        lead_max <= lead_max_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
      if (wr_hist) begin
        last_stamp[in_data.direction] <= in_data.first_stamp;
        last_seq[in_data.direction] <= in_data.first_seq;
      end
    end
  end

  // A transfer always leaves a result waiting in the output register.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // A stop transfer always reports success.
  a_stop_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.req_type == isc_pkg::REQ_STOP)) |=> out_data.ok)
    else $error("stop request did not report ok");

  // A submit while checking is disabled is always rejected.
  a_idle_submit_rejected: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.req_type == isc_pkg::REQ_SUBMIT) && !running) |=> !out_data.ok)
    else $error("submit accepted while not running");

  // The combined flag agrees with its three parts.
  a_all_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.all_safe == (out_data.shape_safe && out_data.lead_safe &&
                                         out_data.order_safe)))
    else $error("combined flag disagrees with safety flags");

  // Capture descriptors are a subset of all scheduled descriptors.
  a_capture_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.capture_count <= out_data.scheduled_count))
    else $error("capture count exceeds scheduled count");

endmodule
